@@ rtl/ssm_pkg.sv @@
// ssm_pkg: shared types and constants of the stream substring matcher
// used by ssm_cell, ssm_out_buf and stream_substring_matcher; no dependencies
`timescale 1ns / 1ps

package ssm_pkg;

    localparam int CHAR_W          = 21;
    localparam int POS_W           = 17;
    localparam int PLEN_W          = 4;
    localparam int MAX_PATTERN     = 8;
    localparam int PAT_IDX_W       = $clog2(MAX_PATTERN);
    localparam int MAX_TEXT_LENGTH = 65536;
    localparam int PAIR_COUNT      = 4;
    localparam int PAIR_W          = 2 * CHAR_W;
    localparam int APB_DATA_W      = 64;
    localparam int APB_ADDR_W      = 6;
    localparam int REG_IDX_W       = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PATTERN_LENGTH = 3'd0,
        REG_PATTERN_PAIR_0 = 3'd1,
        REG_PATTERN_PAIR_1 = 3'd2,
        REG_PATTERN_PAIR_2 = 3'd3,
        REG_PATTERN_PAIR_3 = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic take;
        logic clear;
    } cell_ctrl_t;

    typedef struct packed {
        logic             first_found;
        logic [POS_W-1:0] first_position;
        logic             last_found;
        logic [POS_W-1:0] last_position;
        logic             ends_with_pattern;
        logic             text_too_long;
    } ssm_result_t;

endpackage

@@ rtl/ssm_cell.sv @@
// ssm_cell: one pattern position; holds the partial-match bit for its prefix
// depends on ssm_pkg
`timescale 1ns / 1ps

module ssm_cell
    import ssm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctrl_t        ctrl,
    input  logic [CHAR_W-1:0] text_char,
    input  logic [CHAR_W-1:0] pat_char,
    input  logic              prev_prefix,
    output logic              hit,
    output logic              prefix
);

    logic prefix_reg;
    logic prefix_next;

    assign hit = prev_prefix && (text_char == pat_char);

    always_comb
    begin
        if (ctrl.clear)
        begin
            prefix_next = 1'b0;
        end
        else if (ctrl.take)
        begin
            prefix_next = hit;
        end
        else
        begin
            prefix_next = prefix_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= 1'b0;
        end
        else
        begin
            prefix_reg <= prefix_next;
        end
    end

    assign prefix = prefix_reg;

endmodule

@@ rtl/ssm_out_buf.sv @@
// ssm_out_buf: two-slot result buffer (output register plus skid slot)
// depends on ssm_pkg
`timescale 1ns / 1ps

module ssm_out_buf
    import ssm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  ssm_result_t push_data,
    input  logic        out_stall,
    output logic        out_valid,
    output ssm_result_t out_data,
    output logic        full
);

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    ssm_result_t out_data_reg;
    ssm_result_t out_data_next;
    ssm_result_t skid_data_reg;
    ssm_result_t skid_data_next;
    logic        pop;

    assign pop = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (out_valid_reg)
        begin
            if (pop && push)
            begin
                out_data_next = push_data;
            end
            else if (pop)
            begin
                out_valid_next = 1'b0;
            end
            else if (push)
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (push)
        begin
            out_data_next  = push_data;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign full      = skid_valid_reg;

endmodule

@@ rtl/stream_substring_matcher.sv @@
// stream_substring_matcher: top level with config registers, cell row and result tracking
// depends on ssm_pkg, ssm_cell and ssm_out_buf
`timescale 1ns / 1ps

// Takes one text character per clock cycle while in_stall is low. A row of eight
// cells, one per pattern position, passes partial-match bits along at each
// character, so a match ending at the current character is known in the cycle it
// arrives. The result of a text appears on the output in the cycle after the item
// carrying text_last is accepted when no earlier result is waiting there; otherwise
// it waits in the second slot. Two result slots sit at the output: in_stall rises
// only when both hold results that the downstream side has not yet taken. Characters
// beyond 65536 per text are dropped and flagged. The pattern registers sit at byte
// addresses 0, 8, 16, 24 and 32 and should be written only between texts.

module stream_substring_matcher
    import ssm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [CHAR_W-1:0]     text_char,
    input  logic                  char_valid,
    input  logic                  text_last,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  first_found,
    output logic [POS_W-1:0]      first_position,
    output logic                  last_found,
    output logic [POS_W-1:0]      last_position,
    output logic                  ends_with_pattern,
    output logic                  text_too_long
);

    logic [PLEN_W-1:0] pattern_length_reg;
    logic [PAIR_W-1:0] pattern_pair_reg [PAIR_COUNT];
    reg_index_t        reg_idx;
    logic              cfg_write;

    logic [POS_W-1:0]  chars_seen_reg;
    logic [POS_W-1:0]  chars_seen_next;
    logic              have_first_reg;
    logic              have_first_next;
    logic [POS_W-1:0]  earliest_reg;
    logic [POS_W-1:0]  earliest_next;
    logic [POS_W-1:0]  latest_reg;
    logic [POS_W-1:0]  latest_next;
    logic              match_reg;
    logic              match_next;
    logic              overflow_reg;
    logic              overflow_next;

    logic [PLEN_W-1:0] plen;
    logic              accept;
    logic              close;
    logic              sat;
    logic              take;
    logic              drop;
    logic              full_hit;
    logic [POS_W-1:0]  start_pos;
    cell_ctrl_t        ctrl;
    logic [MAX_PATTERN-1:0] hit_vec;
    logic [MAX_PATTERN:0]   prefix_vec;
    ssm_result_t       result;
    ssm_result_t       out_data;
    logic              buf_full;

    // configuration port
    assign pready    = 1'b1;
    assign reg_idx   = reg_index_t'(paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
            for (int i = 0; i < PAIR_COUNT; i++)
            begin
                pattern_pair_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_PATTERN_LENGTH: pattern_length_reg  <= pwdata[PLEN_W-1:0];
                REG_PATTERN_PAIR_0: pattern_pair_reg[0] <= pwdata[PAIR_W-1:0];
                REG_PATTERN_PAIR_1: pattern_pair_reg[1] <= pwdata[PAIR_W-1:0];
                REG_PATTERN_PAIR_2: pattern_pair_reg[2] <= pwdata[PAIR_W-1:0];
                REG_PATTERN_PAIR_3: pattern_pair_reg[3] <= pwdata[PAIR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_PATTERN_LENGTH: prdata = APB_DATA_W'(pattern_length_reg);
            REG_PATTERN_PAIR_0: prdata = APB_DATA_W'(pattern_pair_reg[0]);
            REG_PATTERN_PAIR_1: prdata = APB_DATA_W'(pattern_pair_reg[1]);
            REG_PATTERN_PAIR_2: prdata = APB_DATA_W'(pattern_pair_reg[2]);
            REG_PATTERN_PAIR_3: prdata = APB_DATA_W'(pattern_pair_reg[3]);
            default:            prdata = '0;
        endcase
    end

    // control
    assign plen   = (pattern_length_reg > PLEN_W'(MAX_PATTERN)) ?
                    PLEN_W'(MAX_PATTERN) : pattern_length_reg;
    assign accept = in_valid && !in_stall;
    assign close  = accept && text_last;
    assign sat    = (chars_seen_reg == POS_W'(MAX_TEXT_LENGTH));
    assign take   = accept && char_valid && !sat;
    assign drop   = accept && char_valid && sat;

    assign ctrl.take  = take;
    assign ctrl.clear = close;

    // cell row
    assign prefix_vec[0] = 1'b1;

    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_cell
        ssm_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .text_char   (text_char),
            .pat_char    (pattern_pair_reg[k / 2][(k % 2) * CHAR_W +: CHAR_W]),
            .prev_prefix (prefix_vec[k]),
            .hit         (hit_vec[k]),
            .prefix      (prefix_vec[k + 1])
        );
    end

    assign full_hit  = take && (plen != '0) &&
                       hit_vec[PAT_IDX_W'(plen - PLEN_W'(1))];
    assign start_pos = chars_seen_reg + POS_W'(1) - POS_W'(plen);

    // position tracking
    always_comb
    begin
        chars_seen_next = take ? chars_seen_reg + POS_W'(1) : chars_seen_reg;
        have_first_next = have_first_reg || full_hit;
        earliest_next   = (full_hit && !have_first_reg) ? start_pos : earliest_reg;
        latest_next     = full_hit ? start_pos : latest_reg;
        match_next      = take ? full_hit : match_reg;
        overflow_next   = overflow_reg || drop;

        result = '0;
        result.text_too_long = overflow_next;
        if (!overflow_next)
        begin
            if (plen == '0)
            begin
                result.first_found       = 1'b1;
                result.last_found        = 1'b1;
                result.last_position     = chars_seen_next;
                result.ends_with_pattern = 1'b1;
            end
            else if (have_first_next)
            begin
                result.first_found       = 1'b1;
                result.last_found        = 1'b1;
                result.first_position    = earliest_next;
                result.last_position     = latest_next;
                result.ends_with_pattern = match_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_seen_reg <= '0;
            have_first_reg <= 1'b0;
            earliest_reg   <= '0;
            latest_reg     <= '0;
            match_reg      <= 1'b0;
            overflow_reg   <= 1'b0;
        end
        else if (close)
        begin
            chars_seen_reg <= '0;
            have_first_reg <= 1'b0;
            earliest_reg   <= '0;
            latest_reg     <= '0;
            match_reg      <= 1'b0;
            overflow_reg   <= 1'b0;
        end
        else
        begin
            chars_seen_reg <= chars_seen_next;
            have_first_reg <= have_first_next;
            earliest_reg   <= earliest_next;
            latest_reg     <= latest_next;
            match_reg      <= match_next;
            overflow_reg   <= overflow_next;
        end
    end

    // result output
    ssm_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (close),
        .push_data (result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .full      (buf_full)
    );

    assign in_stall          = buf_full;
    assign first_found       = out_data.first_found;
    assign first_position    = out_data.first_position;
    assign last_found        = out_data.last_found;
    assign last_position     = out_data.last_position;
    assign ends_with_pattern = out_data.ends_with_pattern;
    assign text_too_long     = out_data.text_too_long;

    // checks
    a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result pending");

    a_found_flags_agree: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (first_found == last_found))
        else $error("first and last found flags differ");

    a_overflow_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && text_too_long) |-> (!first_found && !ends_with_pattern &&
        (first_position == '0) && (last_position == '0)))
        else $error("overflowed text reports a match");

    a_position_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && first_found) |-> (first_position <= last_position))
        else $error("first occurrence after last occurrence");

    a_text_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        close |=> (chars_seen_reg == '0) && !have_first_reg && !overflow_reg)
        else $error("text state not cleared after close");

endmodule

@@ dv/stream_substring_matcher_tb.sv @@
// stream_substring_matcher_tb: self-checking bench for the stream substring matcher
// sends texts and pattern register writes, predicts every result and compares it
// depends on ssm_pkg and the stream_substring_matcher rtl
`timescale 1ns / 1ps

module stream_substring_matcher_tb;
    import ssm_pkg::*;

    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int RANDOM_ITEMS  = 1650;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 10;
    localparam int REPORT_CAP    = 100;
    localparam int UNMAPPED_REG  = 5;
    localparam logic [CHAR_W-1:0] MAX_CODE_POINT = 21'h10FFFF;

    typedef enum logic {ROW_WRITE, ROW_ITEM} dir_kind_t;
    typedef enum {ALPHA_LOW, ALPHA_HIGH, ALPHA_FULL} alpha_t;
    typedef enum {RX_OPEN, RX_RANDOM, RX_RUNS} rx_t;

    typedef struct {
        dir_kind_t             kind;
        int unsigned           reg_idx;
        logic [APB_DATA_W-1:0] wdata;
        logic [CHAR_W-1:0]     ch;
        logic                  cv;
        logic                  last;
        bit                    typed;
        ssm_result_t           want;
    } dir_row_t;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0] paddr      = '0;
    logic [APB_DATA_W-1:0] pwdata     = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic [CHAR_W-1:0]     text_char  = '0;
    logic                  char_valid = 1'b0;
    logic                  text_last  = 1'b0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic                  first_found;
    logic [POS_W-1:0]      first_position;
    logic                  last_found;
    logic [POS_W-1:0]      last_position;
    logic                  ends_with_pattern;
    logic                  text_too_long;

    // mirror of the pattern registers
    logic [PLEN_W-1:0] cfg_plen = '0;
    logic [PAIR_W-1:0] cfg_pair [PAIR_COUNT];

    // per-text search state
    logic [CHAR_W-1:0] win_chars [MAX_PATTERN-1];
    int                seen_count = 0;
    bit                got_match  = 1'b0;
    logic [POS_W-1:0]  first_at   = '0;
    logic [POS_W-1:0]  latest_at  = '0;
    bit                match_now  = 1'b0;
    bit                too_long   = 1'b0;

    ssm_result_t expected_results [$];
    ssm_result_t oldest;
    dir_row_t    directed_rows [$];

    alpha_t alpha_mode     = ALPHA_FULL;
    bit     back_to_back   = 1'b0;
    int     burst_left     = 0;
    int     random_items   = 0;
    int     mismatch_count = 0;
    int     cycle_count    = 0;
    rx_t    rx_mode        = RX_OPEN;
    int     rx_hold        = 0;
    int     rx_run         = 0;

    stream_substring_matcher u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .text_char         (text_char),
        .char_valid        (char_valid),
        .text_last         (text_last),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .first_found       (first_found),
        .first_position    (first_position),
        .last_found        (last_found),
        .last_position     (last_position),
        .ends_with_pattern (ends_with_pattern),
        .text_too_long     (text_too_long)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    function automatic int active_len();
        return (cfg_plen > MAX_PATTERN) ? MAX_PATTERN : int'(cfg_plen);
    endfunction

    function automatic logic [CHAR_W-1:0] pattern_char_at(input int j);
        logic [PAIR_W-1:0] pair;
        pair = cfg_pair[j / 2];
        return (j % 2) ? pair[PAIR_W-1:CHAR_W] : pair[CHAR_W-1:0];
    endfunction

    function automatic logic [CHAR_W-1:0] pick_text_char();
        case (alpha_mode)
            ALPHA_LOW:  return CHAR_W'($urandom_range(0, 3));
            ALPHA_HIGH: return MAX_CODE_POINT - CHAR_W'($urandom_range(0, 3));
            default:    return CHAR_W'($urandom_range(0, MAX_CODE_POINT));
        endcase
    endfunction

    function automatic ssm_result_t result_of(input logic found, input int first_pos,
                                              input int last_pos, input logic ends,
                                              input logic overflow);
        ssm_result_t r;
        r.first_found       = found;
        r.first_position    = POS_W'(first_pos);
        r.last_found        = found;
        r.last_position     = POS_W'(last_pos);
        r.ends_with_pattern = ends;
        r.text_too_long     = overflow;
        return r;
    endfunction

    // advances the search state by one item, returns 1 when the item closes a text
    function automatic bit predict_text_item(input logic [CHAR_W-1:0] c, input logic cv,
                                             input logic last, output ssm_result_t r);
        int   plen;
        int   k;
        int   back;
        bit   same;
        logic [CHAR_W-1:0] have;
        plen = active_len();
        r = '0;
        if (cv)
        begin
            if (seen_count >= MAX_TEXT_LENGTH)
                too_long = 1'b1;
            else
            begin
                match_now = 1'b0;
                if (plen > 0 && seen_count + 1 >= plen)
                begin
                    same = 1'b1;
                    for (k = 0; k < plen; k++)
                    begin
                        back = plen - 1 - k;
                        have = (back == 0) ? c : win_chars[back - 1];
                        if (have != pattern_char_at(k))
                            same = 1'b0;
                    end
                    if (same)
                    begin
                        if (!got_match)
                        begin
                            got_match = 1'b1;
                            first_at  = POS_W'(seen_count + 1 - plen);
                        end
                        latest_at = POS_W'(seen_count + 1 - plen);
                        match_now = 1'b1;
                    end
                end
                for (k = MAX_PATTERN - 2; k > 0; k--)
                    win_chars[k] = win_chars[k - 1];
                win_chars[0] = c;
                seen_count++;
            end
        end
        if (!last)
            return 1'b0;
        if (!too_long)
        begin
            if (plen == 0)
                r = result_of(1'b1, 0, seen_count, 1'b1, 1'b0);
            else if (got_match)
                r = result_of(1'b1, first_at, latest_at, match_now, 1'b0);
        end
        r.text_too_long = too_long;
        seen_count = 0;
        got_match  = 1'b0;
        first_at   = '0;
        latest_at  = '0;
        match_now  = 1'b0;
        too_long   = 1'b0;
        return 1'b1;
    endfunction

    task automatic send_item(input logic [CHAR_W-1:0] c, input logic cv, input logic last,
                             input bit typed, input ssm_result_t want);
        ssm_result_t r;
        int          gap;
        in_valid   <= 1'b1;
        text_char  <= c;
        char_valid <= cv;
        text_last  <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (predict_text_item(c, cv, last, r))
            expected_results.push_back(typed ? want : r);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 15);
            gap = back_to_back ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic cfg_write(input int unsigned idx, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx * 8);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PATTERN_LENGTH: cfg_plen = data[PLEN_W-1:0];
            REG_PATTERN_PAIR_0, REG_PATTERN_PAIR_1, REG_PATTERN_PAIR_2, REG_PATTERN_PAIR_3:
                cfg_pair[idx - REG_PATTERN_PAIR_0] = data[PAIR_W-1:0];
            default: ;
        endcase
        // bus back to idle
        @(posedge clk);
    endtask

    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_random_pattern();
        logic [CHAR_W-1:0]            pc [MAX_PATTERN];
        logic [APB_DATA_W-PAIR_W-1:0] junk;
        logic [APB_DATA_W-1:0]        len_word;
        int                           p;
        alpha_mode   = alpha_t'($urandom_range(0, 2));
        back_to_back = ($urandom_range(0, 3) == 0);
        foreach (pc[j])
            pc[j] = pick_text_char();
        for (p = 0; p < PAIR_COUNT; p++)
        begin
            junk = (APB_DATA_W-PAIR_W)'($urandom);
            cfg_write(REG_PATTERN_PAIR_0 + p, {junk, pc[2*p+1], pc[2*p]});
        end
        len_word = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       len_word[PLEN_W-1:0] = 4'd0;
            1:       len_word[PLEN_W-1:0] = 4'd8;
            2:       len_word[PLEN_W-1:0] = 4'd1;
            3:       len_word[PLEN_W-1:0] = PLEN_W'($urandom_range(9, 15));
            default: len_word[PLEN_W-1:0] = PLEN_W'($urandom_range(1, 8));
        endcase
        cfg_write(REG_PATTERN_LENGTH, len_word);
        if ($urandom_range(0, 7) == 0)
            cfg_write(UNMAPPED_REG, {$urandom, $urandom});
    endtask

    task automatic send_long_text(input int n, input int plant_at);
        int                i;
        logic [CHAR_W-1:0] c;
        for (i = 0; i < n; i++)
        begin
            if (i >= plant_at && i < plant_at + 3)
                c = CHAR_W'(i - plant_at + 1);
            else
                c = pick_text_char();
            send_item(c, 1'b1, i == n - 1, 1'b0, '0);
        end
    endtask

    task automatic send_random_text();
        logic [CHAR_W-1:0] chars [$];
        int                len;
        int                plen;
        int                j;
        int                cut;
        bit                close_marker;
        plen = active_len();
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
        while (chars.size() < len)
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    for (j = 0; j < plen; j++)
                        chars.push_back(pattern_char_at(j));
                end
                1:
                begin
                    // possibly broken occurrence: a prefix of the pattern, which may be all of it
                    cut = $urandom_range(0, plen);
                    for (j = 0; j < cut; j++)
                        chars.push_back(pattern_char_at(j));
                end
                2, 3:
                begin
                    if (plen > 0)
                        chars.push_back(pattern_char_at($urandom_range(0, plen - 1)));
                    else
                        chars.push_back(pick_text_char());
                end
                default: chars.push_back(pick_text_char());
            endcase
        end
        close_marker = (chars.size() == 0) || ($urandom_range(0, 4) == 0);
        foreach (chars[k])
        begin
            if ($urandom_range(0, 19) == 0)
                send_item(pick_text_char(), 1'b0, 1'b0, 1'b0, '0);
            send_item(chars[k], 1'b1, !close_marker && k == chars.size() - 1, 1'b0, '0);
        end
        if (close_marker)
            send_item(pick_text_char(), 1'b0, 1'b1, 1'b0, '0);
        random_items += chars.size() + close_marker;
    endtask

    function automatic dir_row_t row_write(input int unsigned idx,
                                           input logic [APB_DATA_W-1:0] data);
        dir_row_t r;
        r.kind    = ROW_WRITE;
        r.reg_idx = idx;
        r.wdata   = data;
        r.ch      = '0;
        r.cv      = 1'b0;
        r.last    = 1'b0;
        r.typed   = 1'b0;
        r.want    = '0;
        return r;
    endfunction

    function automatic dir_row_t row_known(input logic [CHAR_W-1:0] c, input logic cv,
                                           input logic last, input ssm_result_t want);
        dir_row_t r;
        r.kind    = ROW_ITEM;
        r.reg_idx = 0;
        r.wdata   = '0;
        r.ch      = c;
        r.cv      = cv;
        r.last    = last;
        r.typed   = 1'b1;
        r.want    = want;
        return r;
    endfunction

    function automatic dir_row_t row_item(input logic [CHAR_W-1:0] c, input logic cv,
                                          input logic last);
        dir_row_t r;
        r = row_known(c, cv, last, '0);
        r.typed = 1'b0;
        return r;
    endfunction

    function automatic logic [APB_DATA_W-1:0] pack_pair(input logic [CHAR_W-1:0] lo,
                                                        input logic [CHAR_W-1:0] hi);
        return {{(APB_DATA_W-PAIR_W){1'b0}}, hi, lo};
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with no text closed");
            else
            begin
                oldest = expected_results.pop_front();
                if (first_found !== oldest.first_found)
                    report_mismatch($sformatf("first_found %0d, expected %0d",
                                              first_found, oldest.first_found));
                if (first_position !== oldest.first_position)
                    report_mismatch($sformatf("first_position %0d, expected %0d",
                                              first_position, oldest.first_position));
                if (last_found !== oldest.last_found)
                    report_mismatch($sformatf("last_found %0d, expected %0d",
                                              last_found, oldest.last_found));
                if (last_position !== oldest.last_position)
                    report_mismatch($sformatf("last_position %0d, expected %0d",
                                              last_position, oldest.last_position));
                if (ends_with_pattern !== oldest.ends_with_pattern)
                    report_mismatch($sformatf("ends_with_pattern %0d, expected %0d",
                                              ends_with_pattern, oldest.ends_with_pattern));
                if (text_too_long !== oldest.text_too_long)
                    report_mismatch($sformatf("text_too_long %0d, expected %0d",
                                              text_too_long, oldest.text_too_long));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rx_hold == 0)
        begin
            rx_mode = rx_t'($urandom_range(0, 2));
            rx_hold = $urandom_range(50, 400);
        end
        else
            rx_hold--;
        case (rx_mode)
            RX_OPEN:   out_stall <= 1'b0;
            RX_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
            default:
            begin
                if (rx_run == 0)
                begin
                    rx_run = $urandom_range(1, 20);
                    out_stall <= ~out_stall;
                end
                else
                    rx_run--;
            end
        endcase
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        foreach (cfg_pair[p])
            cfg_pair[p] = '0;
        foreach (win_chars[k])
            win_chars[k] = '0;

        // empty pattern after reset
        directed_rows.push_back(row_known('0, 1'b0, 1'b1, result_of(1'b1, 0, 0, 1'b1, 1'b0)));
        directed_rows.push_back(row_known(MAX_CODE_POINT, 1'b1, 1'b1,
                                          result_of(1'b1, 0, 1, 1'b1, 1'b0)));
        // two-char pattern of extreme code points
        directed_rows.push_back(row_write(REG_PATTERN_PAIR_0, pack_pair('0, MAX_CODE_POINT)));
        directed_rows.push_back(row_write(REG_PATTERN_PAIR_3, '1));
        directed_rows.push_back(row_write(REG_PATTERN_LENGTH, 64'd2));
        directed_rows.push_back(row_item('0, 1'b1, 1'b0));
        directed_rows.push_back(row_item(MAX_CODE_POINT, 1'b1, 1'b0));
        directed_rows.push_back(row_item(21'h1234, 1'b0, 1'b0));
        directed_rows.push_back(row_item(MAX_CODE_POINT, 1'b1, 1'b1));
        // pattern longer than text
        directed_rows.push_back(row_known(MAX_CODE_POINT, 1'b1, 1'b1,
                                          result_of(1'b0, 0, 0, 1'b0, 1'b0)));
        // end marker without char closes the text
        directed_rows.push_back(row_item('0, 1'b1, 1'b0));
        directed_rows.push_back(row_item(MAX_CODE_POINT, 1'b1, 1'b0));
        directed_rows.push_back(row_item(21'd7, 1'b0, 1'b1));
        // full eight-char pattern
        directed_rows.push_back(row_write(REG_PATTERN_PAIR_0, pack_pair(21'd1, 21'd2)));
        directed_rows.push_back(row_write(REG_PATTERN_PAIR_1, pack_pair(21'd3, 21'd4)));
        directed_rows.push_back(row_write(REG_PATTERN_PAIR_2, pack_pair(21'd5, 21'd6)));
        directed_rows.push_back(row_write(REG_PATTERN_PAIR_3, pack_pair(21'd7, 21'd8)));
        directed_rows.push_back(row_write(REG_PATTERN_LENGTH, 64'd8));
        for (int i = 1; i <= 8; i++)
            directed_rows.push_back(row_item(CHAR_W'(i), 1'b1, i == 8));
        // length above eight saturates, unmapped register ignored
        directed_rows.push_back(row_write(REG_PATTERN_LENGTH, 64'd15));
        directed_rows.push_back(row_write(UNMAPPED_REG, '1));
        for (int i = 1; i <= 8; i++)
            directed_rows.push_back(row_item(CHAR_W'(i), 1'b1, i == 8));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[n])
        begin
            if (directed_rows[n].kind == ROW_WRITE)
            begin
                drain_and_settle();
                cfg_write(directed_rows[n].reg_idx, directed_rows[n].wdata);
            end
            else
                send_item(directed_rows[n].ch, directed_rows[n].cv, directed_rows[n].last,
                          directed_rows[n].typed, directed_rows[n].want);
        end

        // longest texts: full length, then past the limit
        back_to_back = 1'b1;
        drain_and_settle();
        cfg_write(REG_PATTERN_LENGTH, 64'd0);
        alpha_mode = ALPHA_FULL;
        send_long_text(MAX_TEXT_LENGTH, MAX_TEXT_LENGTH);
        drain_and_settle();
        cfg_write(REG_PATTERN_PAIR_0, pack_pair(21'd1, 21'd2));
        cfg_write(REG_PATTERN_PAIR_1, pack_pair(21'd3, 21'd0));
        cfg_write(REG_PATTERN_LENGTH, 64'd3);
        alpha_mode = ALPHA_LOW;
        send_long_text(MAX_TEXT_LENGTH, MAX_TEXT_LENGTH - 3);
        send_long_text(MAX_TEXT_LENGTH + 4, MAX_TEXT_LENGTH - 3);
        back_to_back = 1'b0;

        while (random_items < RANDOM_ITEMS)
        begin
            drain_and_settle();
            load_random_pattern();
            repeat ($urandom_range(2, 12)) send_random_text();
        end

        drain_and_settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
